>>> hdl/key_value_table_macros.svh
// ----------------------------------------------------------------------------
// key_value_table_macros
// assertion macros shared by the key/value table modules
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_MACROS_SVH
`define KEY_VALUE_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define KVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// invariant
`define KVT_ASSERT_ALW(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define KVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define KVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`define KVT_ASSERT_ALW(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> hdl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// types, codes and sizes of the key/value table
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int DATA_W  = 32;
    localparam int OCNT_W  = 5;

    typedef logic [1:0] t_req;
    localparam t_req REQ_ADD    = 2'd0;
    localparam t_req REQ_SEARCH = 2'd1;
    localparam t_req REQ_REMOVE = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_NEW   = 2'd0;
    localparam t_status ST_FOUND = 2'd1;
    localparam t_status ST_MISS  = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

>>> hdl/kvt_if.sv
// ----------------------------------------------------------------------------
// kvt_if
// request and response channels of the key/value table
// ----------------------------------------------------------------------------
interface kvt_req_if;
    logic                                valid;
    logic                                ready;
    kvt_pkg::t_req                       req_type;
    logic signed [kvt_pkg::DATA_W-1:0]   key;
    logic signed [kvt_pkg::DATA_W-1:0]   value;

    modport source (output valid, req_type, key, value, input ready);
    modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface kvt_rsp_if;
    logic                                valid;
    logic                                ready;
    kvt_pkg::t_status                    status;
    logic signed [kvt_pkg::DATA_W-1:0]   old_value;
    logic [kvt_pkg::OCNT_W-1:0]          entry_count;
    logic                                is_empty;

    modport source (output valid, status, old_value, entry_count, is_empty, input ready);
    modport sink   (input valid, status, old_value, entry_count, is_empty, output ready);
endinterface

>>> hdl/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// request sequencing and response handshake of the key/value table
// ----------------------------------------------------------------------------
`include "key_value_table_macros.svh"

module kvt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output kvt_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `KVT_ASSERT_NXT(a_accept_to_exec, i_clk, i_rst_n, accept, r_state == S_EXEC, "request not executed next")
    `KVT_ASSERT_IMP(a_exec_out_free, i_clk, i_rst_n, o_cmd.exec, !r_out_valid || i_rsp_ready, "response overwritten")
    `KVT_ASSERT_NXT(a_exec_gives_rsp, i_clk, i_rst_n, o_cmd.exec, r_out_valid, "response lost")
    `KVT_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, (r_state == S_EXEC) && r_out_valid && !i_rsp_ready, r_state == S_EXEC, "request dropped under stall")

endmodule

>>> hdl/kvt_datapath.sv
// ----------------------------------------------------------------------------
// kvt_datapath
// key/value storage, parallel key match, update and response registers
// ----------------------------------------------------------------------------
`include "key_value_table_macros.svh"

module kvt_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kvt_pkg::t_cmd                      i_cmd,
    input  kvt_pkg::t_req                      i_req_type,
    input  logic signed [kvt_pkg::DATA_W-1:0]  i_key,
    input  logic signed [kvt_pkg::DATA_W-1:0]  i_value,
    output kvt_pkg::t_status                   o_status,
    output logic signed [kvt_pkg::DATA_W-1:0]  o_old_value,
    output logic [kvt_pkg::OCNT_W-1:0]         o_entry_count,
    output logic                               o_is_empty
);

    localparam int N = kvt_pkg::ENTRIES;
    localparam int W = kvt_pkg::DATA_W;
    localparam int C = kvt_pkg::CNT_W;

    logic signed [W-1:0] r_key [N];
    logic signed [W-1:0] r_val [N];
    logic [C-1:0]        r_count, n_count;

    kvt_pkg::t_req       r_req_type;
    logic signed [W-1:0] r_req_key;
    logic signed [W-1:0] r_req_val;
    logic [N-1:0]        r_match, n_match;

    kvt_pkg::t_status    r_status, n_status;
    logic signed [W-1:0] r_old, n_old;
    logic [kvt_pkg::OCNT_W-1:0] r_out_count;
    logic                r_out_empty;

    logic                hit;
    logic                full;
    logic [N-1:0]        shift_mask;
    logic signed [W-1:0] hit_val;
    logic                do_replace;
    logic                do_append;
    logic                do_shift;

    // key compare against the held entries
    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_match[i] = (C'(i) < r_count) && (r_key[i] == i_key);
        end
    end

    assign hit        = |r_match;
    assign full       = (r_count == C'(N));
    // entries at and above the matching slot
    assign shift_mask = ~(r_match - N'(1));

    always_comb begin
        hit_val = '0;
        for (int i = 0; i < N; i++) begin
            hit_val = hit_val | (r_val[i] & {W{r_match[i]}});
        end
    end

    always_comb begin
        n_status   = kvt_pkg::ST_MISS;
        n_old      = '0;
        n_count    = r_count;
        do_replace = 1'b0;
        do_append  = 1'b0;
        do_shift   = 1'b0;
        unique case (r_req_type)
            kvt_pkg::REQ_ADD: begin
                if (hit) begin
                    n_status   = kvt_pkg::ST_FOUND;
                    n_old      = hit_val;
                    do_replace = 1'b1;
                end else if (!full) begin
                    n_status  = kvt_pkg::ST_NEW;
                    n_count   = r_count + C'(1);
                    do_append = 1'b1;
                end else begin
                    n_status = kvt_pkg::ST_FULL;
                end
            end
            kvt_pkg::REQ_SEARCH: begin
                if (hit) begin
                    n_status = kvt_pkg::ST_FOUND;
                    n_old    = hit_val;
                end
            end
            kvt_pkg::REQ_REMOVE: begin
                if (hit) begin
                    n_status = kvt_pkg::ST_FOUND;
                    n_old    = hit_val;
                    n_count  = r_count - C'(1);
                    do_shift = 1'b1;
                end
            end
            default: begin
                n_status = kvt_pkg::ST_MISS;
            end
        endcase
    end

    // entry storage
    for (genvar g = 0; g < N; g++) begin : g_entry
        if (g < N - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_cmd.exec) begin
                    if (do_replace && r_match[g]) begin
                        r_val[g] <= r_req_val;
                    end
                    if (do_append && (C'(g) == r_count)) begin
                        r_key[g] <= r_req_key;
                        r_val[g] <= r_req_val;
                    end
                    if (do_shift && shift_mask[g]) begin
                        r_key[g] <= r_key[g+1];
                        r_val[g] <= r_val[g+1];
                    end
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_cmd.exec) begin
                    if (do_replace && r_match[g]) begin
                        r_val[g] <= r_req_val;
                    end
                    if (do_append && (C'(g) == r_count)) begin
                        r_key[g] <= r_req_key;
                        r_val[g] <= r_req_val;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_req_key  <= i_key;
            r_req_val  <= i_value;
            r_match    <= n_match;
        end
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_old       <= n_old;
            r_out_count <= kvt_pkg::OCNT_W'(n_count);
            r_out_empty <= (n_count == '0);
        end
    end

    assign o_status      = r_status;
    assign o_old_value   = r_old;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = r_out_empty;

    `KVT_ASSERT_ALW(a_count_bound, i_clk, i_rst_n, r_count <= C'(N), "pair count above depth")
    `KVT_ASSERT_IMP(a_unique_key, i_clk, i_rst_n, i_cmd.exec, $onehot0(r_match), "duplicate key held")
    `KVT_ASSERT_NXT(a_append_count, i_clk, i_rst_n, i_cmd.exec && do_append, r_count == $past(r_count) + C'(1), "append count wrong")
    `KVT_ASSERT_NXT(a_remove_count, i_clk, i_rst_n, i_cmd.exec && do_shift, r_count == $past(r_count) - C'(1), "remove count wrong")

endmodule

>>> hdl/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table
// key/value store in insertion order with add, search and remove requests
// ----------------------------------------------------------------------------
// i_req carries one request: req_type (add, search, remove), key and value.
// o_rsp returns one response per request: status, old_value, entry_count
// and is_empty after the request.
// A request is taken while the block is idle; in that same cycle the key is
// compared against every held entry in parallel. The execute step that follows,
// once the response register is free, applies the update (replace, append, or
// remove with the later entries shifted down one place) and loads the response
// register. A new request is taken only after that update, as the controller
// moves between its idle and execute states.
// The response register lets the next request be taken while a response
// waits. When the receiver stalls, the second request holds in its update
// step until the waiting response is taken.
// Reset clears the pair count and the handshake state; the store then
// holds no pairs and the block is ready at once.
// ----------------------------------------------------------------------------
module key_value_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kvt_req_if.sink   i_req,
    kvt_rsp_if.source o_rsp
);

    kvt_pkg::t_cmd cmd;

    kvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    kvt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req.req_type),
        .i_key         (i_req.key),
        .i_value       (i_req.value),
        .o_status      (o_rsp.status),
        .o_old_value   (o_rsp.old_value),
        .o_entry_count (o_rsp.entry_count),
        .o_is_empty    (o_rsp.is_empty)
    );

endmodule
